FILE: rtl/segx_pkg.sv
// ----------------------------------------------------------------------------
// segx_pkg: shared types and constants for the segment intersection block
// Widths, status codes and the stage payload structs used by every module.
// ----------------------------------------------------------------------------
package segx_pkg;

	localparam int CW      = 16;            // coordinate width
	localparam int TF      = 16;            // fraction bits of t
	localparam int DW      = CW + 1;        // coordinate difference width
	localparam int PW      = 2 * DW + 1;    // cross product width
	localparam int QW      = TF + 1;        // quotient width
	localparam int MW      = DW + QW + 1;   // product width for the point

	typedef enum logic [1:0] {
		ST_BOX    = 2'd0,
		ST_PARA   = 2'd1,
		ST_RANGE  = 2'd2,
		ST_HIT    = 2'd3
	} status_t;

	// Payload leaving the cross-product front end.
	typedef struct packed {
		logic                 ok;      // still a candidate for a hit
		status_t              status;
		logic [PW-1:0]        num;     // normalized tTop
		logic [PW-1:0]        den;     // normalized bottom
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [DW-1:0] ex;      // bx - ax
		logic signed [DW-1:0] ey;      // by - ay
	} front_t;

	// Payload carried through the divider stages.
	typedef struct packed {
		logic                 ok;
		status_t              status;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [DW-1:0] ex;
		logic signed [DW-1:0] ey;
	} side_t;

endpackage

FILE: rtl/segx_front.sv
// ----------------------------------------------------------------------------
// segx_front: box test and cross products
// Three register stages: differences and box test, products, then sign fix.
// ----------------------------------------------------------------------------
module segx_front import segx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] ax,
	input  logic signed [CW-1:0] ay,
	input  logic signed [CW-1:0] bx,
	input  logic signed [CW-1:0] by_coord,
	input  logic signed [CW-1:0] cx,
	input  logic signed [CW-1:0] cy,
	input  logic signed [CW-1:0] dx,
	input  logic signed [CW-1:0] dy,
	output logic                 out_valid,
	output front_t               out_data
);
	logic                 v_s1, v_s2, v_s3;
	logic                 box_s1, box_s2;
	logic signed [CW-1:0] ax_s1, ay_s1, ax_s2, ay_s2;
	logic signed [DW-1:0] ex_s1, ey_s1, fx_s1, fy_s1, gx_s1, gy_s1;
	logic signed [DW-1:0] ex_s2, ey_s2;
	logic signed [PW-1:0] tt_s2, uu_s2, bb_s2;
	front_t               f_s3;

	logic signed [CW-1:0] mnay, mxay, mncy, mxcy, mnax, mxax, mncx, mxcx;
	logic                 reject;

	always_comb begin
		mnay = (ay < by_coord) ? ay : by_coord;
		mxay = (ay > by_coord) ? ay : by_coord;
		mncy = (cy < dy) ? cy : dy;
		mxcy = (cy > dy) ? cy : dy;
		mnax = (ax < bx) ? ax : bx;
		mxax = (ax > bx) ? ax : bx;
		mncx = (cx < dx) ? cx : dx;
		mxcx = (cx > dx) ? cx : dx;
		reject = (mnay > mxcy) || (mncy > mxay) || (mnax > mxcx) || (mncx > mxax);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: differences. e = B-A, f = D-C, g = A-C.
	always_ff @(posedge clk) begin
		if (en) begin
			box_s1 <= ~reject;
			ax_s1  <= ax;
			ay_s1  <= ay;
			ex_s1  <= DW'(bx) - DW'(ax);
			ey_s1  <= DW'(by_coord) - DW'(ay);
			fx_s1  <= DW'(dx) - DW'(cx);
			fy_s1  <= DW'(dy) - DW'(cy);
			gx_s1  <= DW'(ax) - DW'(cx);
			gy_s1  <= DW'(ay) - DW'(cy);
		end
	end

	// Stage 2: tTop = fx*gy - fy*gx, uTop = ex*gy - ey*gx, bottom = fy*ex - fx*ey.
	always_ff @(posedge clk) begin
		if (en) begin
			box_s2 <= box_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			ex_s2  <= ex_s1;
			ey_s2  <= ey_s1;
			tt_s2  <= PW'(fx_s1 * gy_s1) - PW'(fy_s1 * gx_s1);
			uu_s2  <= PW'(ex_s1 * gy_s1) - PW'(ey_s1 * gx_s1);
			bb_s2  <= PW'(fy_s1 * ex_s1) - PW'(fx_s1 * ey_s1);
		end
	end

	// Stage 3: flip all signs when bottom is negative, then classify.
	logic signed [PW-1:0] tn, un, bn;
	always_comb begin
		tn = bb_s2[PW-1] ? -tt_s2 : tt_s2;
		un = bb_s2[PW-1] ? -uu_s2 : uu_s2;
		bn = bb_s2[PW-1] ? -bb_s2 : bb_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s3.ax  <= ax_s2;
			f_s3.ay  <= ay_s2;
			f_s3.ex  <= ex_s2;
			f_s3.ey  <= ey_s2;
			f_s3.num <= tn;
			f_s3.den <= bn;
			if (!box_s2) begin
				f_s3.ok     <= 1'b0;
				f_s3.status <= ST_BOX;
			end else if (bb_s2 == '0) begin
				f_s3.ok     <= 1'b0;
				f_s3.status <= ST_PARA;
			end else if (tn < 0 || tn > bn || un < 0 || un > bn) begin
				f_s3.ok     <= 1'b0;
				f_s3.status <= ST_RANGE;
			end else begin
				f_s3.ok     <= 1'b1;
				f_s3.status <= ST_HIT;
			end
		end
	end

	assign out_valid = v_s3;
	assign out_data  = f_s3;
endmodule

FILE: rtl/segx_div.sv
// ----------------------------------------------------------------------------
// segx_div: pipelined restoring divider
// One quotient bit per stage: t = floor(num * 2^TF / den) for num <= den.
// ----------------------------------------------------------------------------
module segx_div import segx_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  front_t        in_data,
	output logic          out_valid,
	output side_t         out_side,
	output logic [QW-1:0] out_q
);
	// Stage k holds the remainder after producing k+1 quotient bits.
	logic [QW-1:0]      v_s;
	logic [PW:0]        r_s  [QW];
	logic [PW-1:0]      d_s  [QW];
	logic [QW-1:0]      q_s  [QW];
	side_t              sd_s [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[QW-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// First stage: integer bit, which is 1 when num >= den, so for num <= den only when they are equal.
			d_s[0]  <= in_data.den;
			sd_s[0] <= '{ok: in_data.ok, status: in_data.status, ax: in_data.ax,
				ay: in_data.ay, ex: in_data.ex, ey: in_data.ey};
			if (in_data.num >= in_data.den) begin
				r_s[0] <= (PW+1)'(in_data.num - in_data.den);
				q_s[0] <= QW'(1);
			end else begin
				r_s[0] <= (PW+1)'(in_data.num);
				q_s[0] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= QW - 1; k++) begin : g_bit
		logic [PW:0] sh;
		assign sh = {r_s[k-1][PW-1:0], 1'b0};
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k]  <= d_s[k-1];
				sd_s[k] <= sd_s[k-1];
				if (sh >= (PW+1)'(d_s[k-1])) begin
					r_s[k] <= sh - (PW+1)'(d_s[k-1]);
					q_s[k] <= {q_s[k-1][QW-2:0], 1'b1};
				end else begin
					r_s[k] <= sh;
					q_s[k] <= {q_s[k-1][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_side  = sd_s[QW-1];
	assign out_q     = q_s[QW-1];
endmodule

FILE: rtl/segx_point.sv
// ----------------------------------------------------------------------------
// segx_point: intersection point from t
// Multiplies the edge vector by t, then floors and adds the start point; a miss gets a zero point and t.
// ----------------------------------------------------------------------------
module segx_point import segx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  side_t                in_side,
	input  logic [QW-1:0]        in_q,
	output logic                 out_valid,
	output logic                 hit,
	output status_t              status,
	output logic signed [CW-1:0] ix,
	output logic signed [CW-1:0] iy,
	output logic [QW-1:0]        t_offset
);
	logic                 v_s1, v_s2;
	side_t                sd_s1;
	logic [QW-1:0]        q_s1;
	logic signed [MW-1:0] px_s1, py_s1;
	logic                 h_s2;
	status_t              st_s2;
	logic signed [CW-1:0] ix_s2, iy_s2;
	logic [QW-1:0]        q_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1 <= in_side;
			q_s1  <= in_q;
			px_s1 <= MW'(in_side.ex) * $signed({1'b0, in_q});
			py_s1 <= MW'(in_side.ey) * $signed({1'b0, in_q});
		end
	end

	// An arithmetic shift right floors, matching the reference rounding.
	logic signed [MW-1:0] fx, fy;
	assign fx = px_s1 >>> TF;
	assign fy = py_s1 >>> TF;

	always_ff @(posedge clk) begin
		if (en) begin
			h_s2  <= sd_s1.ok;
			st_s2 <= sd_s1.status;
			ix_s2 <= sd_s1.ok ? CW'(sd_s1.ax + fx[CW-1:0]) : '0;
			iy_s2 <= sd_s1.ok ? CW'(sd_s1.ay + fy[CW-1:0]) : '0;
			q_s2  <= sd_s1.ok ? q_s1 : '0;
		end
	end

	assign out_valid = v_s2;
	assign hit       = h_s2;
	assign status    = st_s2;
	assign ix        = ix_s2;
	assign iy        = iy_s2;
	assign t_offset  = q_s2;
endmodule

FILE: rtl/segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_intersection: 2-D segment intersection pipeline
// Box test, exact cross products, a bit-per-stage divider for t and the point.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  s_axis  | in  | ax, ay, bx, by_coord, cx, cy, dx, dy (16 bits each)
//  m_axis  | out | ix, iy, t_offset in tdata; hit, status in tuser
//
// One pair enters per cycle unless the pipeline stalls; a pair passes the
// front end, the 17 divider stages (one per quotient bit), the point stages and then the output register.
// Reset clears all valid bits; payload registers are not reset.
// The whole pipeline advances together: it stalls only when the output
// register is full and not taken, so a stall neither drops nor repeats.
module segment_intersection import segx_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // ax, ay, bx, by_coord, cx, cy, dx, dy
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [55:0]  m_axis_tdata,  // ix, iy, t_offset, zero pad
	output logic [2:0]   m_axis_tuser   // hit, status
);
	logic    en;
	logic    f_v, d_v, p_v;
	front_t  f_d;
	side_t   d_side;
	logic [QW-1:0] d_q;
	logic    p_hit;
	status_t p_st;
	logic signed [CW-1:0] p_ix, p_iy;
	logic [QW-1:0] p_t;
	logic    o_v_q;

	// The pipeline moves whenever the output register is free or being read.
	assign en            = ~o_v_q | m_axis_tready;
	assign s_axis_tready = en;

	segx_front u_front (
		.clk, .arst_n, .en,
		.in_valid (s_axis_tvalid),
		.ax       (s_axis_tdata[15:0]),
		.ay       (s_axis_tdata[31:16]),
		.bx       (s_axis_tdata[47:32]),
		.by_coord (s_axis_tdata[63:48]),
		.cx       (s_axis_tdata[79:64]),
		.cy       (s_axis_tdata[95:80]),
		.dx       (s_axis_tdata[111:96]),
		.dy       (s_axis_tdata[127:112]),
		.out_valid(f_v),
		.out_data (f_d)
	);

	segx_div u_div (
		.clk, .arst_n, .en,
		.in_valid (f_v),
		.in_data  (f_d),
		.out_valid(d_v),
		.out_side (d_side),
		.out_q    (d_q)
	);

	segx_point u_point (
		.clk, .arst_n, .en,
		.in_valid (d_v),
		.in_side  (d_side),
		.in_q     (d_q),
		.out_valid(p_v),
		.hit      (p_hit),
		.status   (p_st),
		.ix       (p_ix),
		.iy       (p_iy),
		.t_offset (p_t)
	);

	// Output register: holds a finished transfer until the sink takes it.
	logic [55:0] o_data_q;
	logic [2:0]  o_user_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
		end else if (en) begin
			o_v_q <= p_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_data_q <= {7'd0, p_t, p_iy, p_ix};
			o_user_q <= {p_st, p_hit};
		end
	end

	assign m_axis_tvalid = o_v_q;
	assign m_axis_tdata  = o_data_q;
	assign m_axis_tuser  = o_user_q;

	// A hit always carries the hit status code, and a miss a zero point.
	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[2:1] == ST_HIT)))
		else $error("hit flag and status disagree");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("miss carries nonzero result");
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[48]) |-> (m_axis_tdata[47:32] == '0))
		else $error("t exceeds one");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result changed during stall");
endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the segment intersection pipeline
// Drives segment pairs over the input stream with random gaps, predicts the
// hit, status, point and t of each pair, and checks every output transfer.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import segx_pkg::*;

	// Expected result of one segment pair.
	typedef struct {
		logic          hit;
		status_t       status;
		logic [15:0]   ix;
		logic [15:0]   iy;
		logic [16:0]   t_offset;
	} isect_t;

	// Holds the predicted results in order and compares the block's results
	// against them.
	class isect_board;
		isect_t pending[$];
		int     errors;

		function new();
			errors = 0;
		endfunction

		// Computes the expected result for one pair and queues it.
		function void note_pair(logic [127:0] d);
			longint ax, ay, bx, by, cx, cy, dx, dy;
			longint tt, ut, bt, px, py, p, q, r;
			isect_t e;
			ax = longint'($signed(d[15:0]));
			ay = longint'($signed(d[31:16]));
			bx = longint'($signed(d[47:32]));
			by = longint'($signed(d[63:48]));
			cx = longint'($signed(d[79:64]));
			cy = longint'($signed(d[95:80]));
			dx = longint'($signed(d[111:96]));
			dy = longint'($signed(d[127:112]));
			e.hit = 1'b0;
			e.status = ST_BOX;
			e.ix = '0;
			e.iy = '0;
			e.t_offset = '0;
			// Bounding boxes, y first then x; equal edges overlap.
			if ((ay < by ? ay : by) > (cy > dy ? cy : dy) ||
			    (cy < dy ? cy : dy) > (ay > by ? ay : by) ||
			    (ax < bx ? ax : bx) > (cx > dx ? cx : dx) ||
			    (cx < dx ? cx : dx) > (ax > bx ? ax : bx)) begin
				pending.push_back(e);
				return;
			end
			tt = (dx - cx) * (ay - cy) - (dy - cy) * (ax - cx);
			ut = (cy - ay) * (ax - bx) - (cx - ax) * (ay - by);
			bt = (dy - cy) * (bx - ax) - (dx - cx) * (by - ay);
			if (bt == 0) begin
				e.status = ST_PARA;
			end else begin
				if (bt < 0) begin
					bt = -bt;
					tt = -tt;
					ut = -ut;
				end
				if (tt < 0 || tt > bt || ut < 0 || ut > bt) begin
					e.status = ST_RANGE;
				end else begin
					// tTop <= bottom, so the scaled value fits easily.
					q = (tt <<< TF) / bt;
					p = (bx - ax) * q;
					px = ax + (p >>> TF);
					r = (by - ay) * q;
					py = ay + (r >>> TF);
					e.hit = 1'b1;
					e.status = ST_HIT;
					e.ix = px[15:0];
					e.iy = py[15:0];
					e.t_offset = q[16:0];
				end
			end
			pending.push_back(e);
		endfunction

		function void check_result(logic [55:0] d, logic [2:0] u);
			isect_t e;
			if (pending.size() == 0) begin
				$error("result transfer with no pair outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (u[0] !== e.hit) begin
				$error("hit: expected %0d, got %0d", e.hit, u[0]);
				errors++;
			end
			if (u[2:1] !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, u[2:1]);
				errors++;
			end
			if (d[15:0] !== e.ix) begin
				$error("ix: expected %h, got %h", e.ix, d[15:0]);
				errors++;
			end
			if (d[31:16] !== e.iy) begin
				$error("iy: expected %h, got %h", e.iy, d[31:16]);
				errors++;
			end
			if (d[48:32] !== e.t_offset) begin
				$error("t_offset: expected %h, got %h", e.t_offset, d[48:32]);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [55:0]  m_axis_tdata;
	logic [2:0]   m_axis_tuser;

	isect_board board;
	bit         hold_now;   // long receiver hold-off requested

	segment_intersection u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Random gap length; more than a third of the time there is no gap at all, which
	// gives long back-to-back stretches.
	function automatic int pick_gap();
		if ($urandom_range(2) == 0)
			return 0;
		return $urandom_range(14);
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($signed($urandom_range(64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	// Sends one pair: waits out the gap, offers it, and holds it until the
	// transfer. Valid stays high into the next pair when there is no gap.
	task automatic send_pair(logic [15:0] a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {d_y, d_x, c_y, c_x, b_y, b_x, a_y, a_x};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_pair({d_y, d_x, c_y, c_x, b_y, b_x, a_y, a_x});
		@(negedge clk);
	endtask

	// Crossing pair built around a random center so most land as hits.
	task automatic send_crossing();
		int cxm, cym, r1, r2;
		logic [15:0] p[8];
		cxm = $signed($urandom_range(40000)) - 20000;
		cym = $signed($urandom_range(40000)) - 20000;
		r1 = $urandom_range(12000);
		r2 = $urandom_range(12000);
		p[0] = 16'(cxm - $signed($urandom_range(r1)));
		p[1] = 16'(cym - $signed($urandom_range(r1)));
		p[2] = 16'(cxm + $signed($urandom_range(r1)));
		p[3] = 16'(cym + $signed($urandom_range(r1)));
		p[4] = 16'(cxm + $signed($urandom_range(r2)));
		p[5] = 16'(cym - $signed($urandom_range(r2)));
		p[6] = 16'(cxm - $signed($urandom_range(r2)));
		p[7] = 16'(cym + $signed($urandom_range(r2)));
		if ($urandom_range(1)) begin
			// Swap the endpoints of both segments; both directions reverse, so the sign of the denominator stays the same.
			send_pair(p[2], p[3], p[0], p[1], p[4], p[5], p[6], p[7]);
		end else begin
			send_pair(p[0], p[1], p[2], p[3], p[6], p[7], p[4], p[5]);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off requested by the
	// sender side while it keeps offering pairs.
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_now) begin
				m_axis_tready <= 1'b0;
				repeat (150) @(negedge clk);
				hold_now = 1'b0;
			end
			gap = pick_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
				@(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// Checks at every rising edge where a result transfer happens.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Main sequence: reset, directed pairs, random pairs, drain.
	initial begin
		int n;
		board = new();
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		hold_now = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Plain crossing at the origin.
		send_pair(-16'sd16, -16'sd16, 16'sd16, 16'sd16, -16'sd16, 16'sd16, 16'sd16, -16'sd16);
		// Boxes apart in y, then in x.
		send_pair(0, 0, 16, 16, 0, 100, 16, 200);
		send_pair(0, 0, 16, 16, 100, 0, 200, 16);
		// Touching boxes: shared corner counts as a hit at t = 1.
		send_pair(0, 0, 16, 16, 16, 16, 32, 0);
		// Touching boxes at t = 0.
		send_pair(0, 0, 16, 16, 0, 0, -16, 32);
		// Parallel, collinear overlapping, and a point segment.
		send_pair(0, 0, 32, 0, 0, 0, 32, 0);
		send_pair(0, 0, 32, 32, 16, 16, 48, 48);
		send_pair(5, 5, 5, 5, 0, 0, 16, 16);
		send_pair(0, 0, 32, 0, 0, 1, 32, 1);
		// Boxes overlap but lines cross outside one segment.
		send_pair(0, 0, 64, 64, 60, 0, 64, 2);
		// Extremes of the coordinate range.
		send_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
		          16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		send_pair(16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
		          16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
		send_pair(16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
		          16'h8000, 16'h8000, 16'h7fff, 16'h7ffe);
		send_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff,
		          16'hffff, 16'hffff, 16'hffff, 16'hffff);
		// Uneven t with negative directions, so the floor matters.
		send_pair(30, 7, -29, -3, -5, 40, 3, -41);
		send_pair(-1, 0, -100, -3, -50, 9, -50, -20);

		for (n = 0; n < 1750; n++) begin
			if (n == 300)
				hold_now = 1'b1;
			case ($urandom_range(9))
				0, 1: send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				                rand_coord(), rand_coord(), rand_coord(), rand_coord());
				2: begin
					// Parallel by construction: same direction, shifted.
					logic [15:0] x0, y0, ddx, ddy, ox, oy;
					x0 = 16'($signed($urandom_range(20000)) - 10000);
					y0 = 16'($signed($urandom_range(20000)) - 10000);
					ddx = 16'($signed($urandom_range(8000)) - 4000);
					ddy = 16'($signed($urandom_range(8000)) - 4000);
					ox = 16'($urandom_range(4) * ddx);
					oy = 16'($urandom_range(4) * ddy);
					send_pair(x0, y0, x0 + ddx, y0 + ddy, x0 + ox, y0 + oy,
					          x0 + ox + ddx, y0 + oy + ddy);
				end
				default: send_crossing();
			endcase
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Run limit, far beyond the slowest legal run.
	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
